### rtl/fnvlkp_pkg.sv
// ----------------------------------------------------------------------------
// fnvlkp_pkg
// Shared types, constants and the FNV-1a step (byte sign-extended before the XOR) for the path hash lookup block.
// ----------------------------------------------------------------------------
package fnvlkp_pkg;

   localparam int unsigned OPC_W           = 2;
   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned SLOT_W          = 6;
   localparam int unsigned HASH_W          = 32;
   localparam int unsigned CFG_W           = 7;
   localparam int unsigned IDX_W           = 6;
   localparam int unsigned DEF_TABLE_DEPTH = 64;

   localparam int unsigned REQ_TDATA_W = 48;
   localparam int unsigned RSP_TDATA_W = 40;
   localparam int unsigned CSR_TDATA_W = 8;

   localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;
   localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

   typedef enum logic [OPC_W-1:0] {
      OPC_BYTE   = 2'd0,
      OPC_LOOKUP = 2'd1,
      OPC_WRITE  = 2'd2,
      OPC_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic hash_byte;
      logic write_entry;
      logic start_scan;
      logic issue_read;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic limit_zero;
      logic last_read;
      logic match;
      logic out_free;
   } status_type;

   function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0]   ext;
      logic [2*HASH_W-1:0] prod;
      ext  = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
      prod = {{HASH_W{1'b0}}, h ^ ext} * {{HASH_W{1'b0}}, FNV_PRIME};
      return prod[HASH_W-1:0];
   endfunction

endpackage

### rtl/fnvlkp_ram.sv
// ----------------------------------------------------------------------------
// fnvlkp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fnvlkp_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fnvlkp_ctrl.sv
// ----------------------------------------------------------------------------
// fnvlkp_ctrl
// Controller: input handshake, table scan sequencing and result hand-off.
// ----------------------------------------------------------------------------
module fnvlkp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  fnvlkp_pkg::opcode_type opcode,
   input  fnvlkp_pkg::status_type status,
   output logic                   req_tready,
   output fnvlkp_pkg::cmd_type    cmd
);
   import fnvlkp_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      req_accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && opcode == OPC_LOOKUP) begin
               state_in = status.limit_zero ? ST_RESULT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.match) begin
               state_in = ST_RESULT;
            end else if (status.last_read) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd             = '0;
      cmd.hash_byte   = req_accept && opcode == OPC_BYTE;
      cmd.write_entry = req_accept && opcode == OPC_WRITE;
      cmd.start_scan  = req_accept && opcode == OPC_LOOKUP;
      case (state_ff)
         ST_SCAN: begin
            cmd.issue_read = !status.match;
         end
         ST_RESULT: begin
            cmd.load_result = status.out_free;
         end
         default: begin
            cmd.issue_read  = 1'b0;
            cmd.load_result = 1'b0;
         end
      endcase
   end

endmodule

### rtl/fnvlkp_dp.sv
// ----------------------------------------------------------------------------
// fnvlkp_dp
// Datapath: running hash, table store, scan compare and result register.
// ----------------------------------------------------------------------------
module fnvlkp_dp #(
   parameter int unsigned TABLE_DEPTH = fnvlkp_pkg::DEF_TABLE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fnvlkp_pkg::cmd_type             cmd,
   input  logic [fnvlkp_pkg::BYTE_W-1:0]   path_byte,
   input  logic [fnvlkp_pkg::SLOT_W-1:0]   write_slot,
   input  logic [fnvlkp_pkg::HASH_W-1:0]   write_hash,
   input  logic                            cfg_write,
   input  logic [fnvlkp_pkg::CFG_W-1:0]    cfg_data,
   input  logic                            rsp_tready,
   output fnvlkp_pkg::status_type          status,
   output logic                            rsp_valid,
   output logic                            rsp_found,
   output logic [fnvlkp_pkg::IDX_W-1:0]    rsp_entry_index,
   output logic [fnvlkp_pkg::HASH_W-1:0]   rsp_path_hash
);
   import fnvlkp_pkg::*;

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [CFG_W-1:0]  table_entries_ff;
   logic [HASH_W-1:0] hash_ff;
   logic [CFG_W-1:0]  cnt_ff;
   logic              rd_vld_ff;
   logic [CFG_W-1:0]  rd_idx_ff;
   logic              found_ff;
   logic [CFG_W-1:0]  found_idx_ff;
   logic              rsp_valid_ff;
   logic              rsp_found_ff;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic [HASH_W-1:0] rsp_hash_ff;

   logic [CFG_W-1:0]  limit;
   logic              slot_ok;
   logic [HASH_W-1:0] rd_data;
   logic              match;

   assign limit   = (int'(table_entries_ff) > int'(TABLE_DEPTH)) ? CFG_W'(TABLE_DEPTH)
                                                                 : table_entries_ff;
   assign slot_ok = int'(write_slot) < int'(TABLE_DEPTH);

   fnvlkp_ram #(
      .WIDTH (HASH_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.write_entry && slot_ok),
      .wr_addr (AW'(write_slot)),
      .wr_data (write_hash),
      .rd_addr (AW'(cnt_ff)),
      .rd_data (rd_data)
   );

   assign match = rd_vld_ff && !found_ff && (rd_data == hash_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         table_entries_ff <= '0;
         hash_ff          <= FNV_BASIS;
         rd_vld_ff        <= 1'b0;
         found_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (cfg_write) begin
            table_entries_ff <= cfg_data;
         end
         if (cmd.hash_byte) begin
            hash_ff <= fnv_step(hash_ff, path_byte);
         end else if (cmd.load_result) begin
            hash_ff <= FNV_BASIS;
         end
         rd_vld_ff <= cmd.issue_read;
         if (cmd.start_scan) begin
            found_ff <= 1'b0;
         end else if (match) begin
            found_ff <= 1'b1;
         end
         if (cmd.load_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_scan) begin
         cnt_ff <= '0;
      end else if (cmd.issue_read) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.issue_read) begin
         rd_idx_ff <= cnt_ff;
      end
      if (match) begin
         found_idx_ff <= rd_idx_ff;
      end
      if (cmd.load_result) begin
         rsp_found_ff <= found_ff;
         rsp_idx_ff   <= found_ff ? found_idx_ff[IDX_W-1:0] : '0;
         rsp_hash_ff  <= hash_ff;
      end
   end

   assign status.limit_zero = (limit == '0);
   assign status.last_read  = (cnt_ff == limit - 1'b1);
   assign status.match      = match;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_entry_index = rsp_idx_ff;
   assign rsp_path_hash   = rsp_hash_ff;

endmodule

### rtl/fnv1a_path_hash_index_lookup.sv
// ----------------------------------------------------------------------------
// fnv1a_path_hash_index_lookup
// FNV-1a path hash (byte sign-extended before the XOR) with lookup in a stored hash table.
//
//   Channel  Dir  Handshake            Payload
//   req      in   req_tvalid/tready    opcode (tuser), path_byte, write_slot, write_hash
//   rsp      out  rsp_tvalid/tready    found, entry_index, path_hash
//   csr      in   csr_tvalid/tready    table_entries
//
// Path byte and table write items are accepted whenever the controller is idle.
// A lookup reads one slot a cycle through the table read port, from slot 0 up to
// the first hit or to slot min(table_entries, depth) - 1, and skips the scan
// when that minimum is zero. The req input is held off until its result is loaded.
// Reset is synchronous; the table is not cleared and holds garbage until written.
// A result waiting on rsp stalls only the end of the next lookup.
// ----------------------------------------------------------------------------
module fnv1a_path_hash_index_lookup #(
   parameter int unsigned TABLE_DEPTH = fnvlkp_pkg::DEF_TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // opcode[1:0]
   input  logic [fnvlkp_pkg::OPC_W-1:0]        req_tuser,
   // path_byte[7:0], write_slot[13:8], write_hash[45:14], zero[47:46]
   input  logic [fnvlkp_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // found[0], entry_index[6:1], path_hash[38:7], zero[39]
   output logic [fnvlkp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                                csr_tvalid,
   output logic                                csr_tready,
   // table_entries[6:0], zero[7]
   input  logic [fnvlkp_pkg::CSR_TDATA_W-1:0]  csr_tdata
);
   import fnvlkp_pkg::*;

   cmd_type           cmd;
   status_type        status;
   opcode_type        opcode;
   logic              rsp_found;
   logic [IDX_W-1:0]  rsp_entry_index;
   logic [HASH_W-1:0] rsp_path_hash;

   assign opcode     = opcode_type'(req_tuser);
   assign csr_tready = 1'b1;

   fnvlkp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .opcode     (opcode),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   fnvlkp_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .path_byte       (req_tdata[7:0]),
      .write_slot      (req_tdata[13:8]),
      .write_hash      (req_tdata[45:14]),
      .cfg_write       (csr_tvalid && csr_tready),
      .cfg_data        (csr_tdata[CFG_W-1:0]),
      .rsp_tready      (rsp_tready),
      .status          (status),
      .rsp_valid       (rsp_tvalid),
      .rsp_found       (rsp_found),
      .rsp_entry_index (rsp_entry_index),
      .rsp_path_hash   (rsp_path_hash)
   );

   assign rsp_tdata = {1'b0, rsp_path_hash, rsp_entry_index, rsp_found};

   a_lookup_blocks_input: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && opcode == OPC_LOOKUP |=> !req_tready)
      else $error("input still accepted after lookup start");

   a_miss_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[6:1] == '0)
      else $error("nonzero entry index on miss");

   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |=> rsp_tvalid)
      else $error("loaded result not presented");

   a_scan_stops_on_hit: assert property (@(posedge clock) disable iff (reset)
      status.match |-> !cmd.issue_read)
      else $error("table read issued after a hit");

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FNV-1a path hash lookup block.
//
// Path bytes, lookups, table writes and unused opcodes go in on the req
// stream. A shadow of the running hash, the slot table and the table size
// setting works out each lookup result, and every rsp item is checked
// against the oldest outstanding one. Every slot is loaded before any lookup
// searches the table. Directed cases come first, among them an rsp hold-off
// that backs the block up. Then comes random traffic that is mostly
// well-formed paths whose hashes sit in the table, with several table size
// settings from 0 to 127.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fnvlkp_pkg::*;

   localparam int unsigned DEPTH          = DEF_TABLE_DEPTH;
   localparam int unsigned RANDOM_ITEMS   = 1500;
   localparam int unsigned IDLE_PCT       = 14;
   localparam int unsigned HOLD_CYCLES    = 200;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned FINAL_CYCLES   = 100;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned MAX_PATH       = 8;

   typedef struct packed {
      logic [HASH_W-1:0] write_hash;
      logic [SLOT_W-1:0] write_slot;
      logic [BYTE_W-1:0] path_byte;
      opcode_type        opcode;
   } req_item_type;

   typedef struct packed {
      logic              pad;
      logic [HASH_W-1:0] path_hash;
      logic [IDX_W-1:0]  entry_index;
      logic              found;
   } lookup_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [OPC_W-1:0]       req_tuser  = '0;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_tvalid = 1'b0;
   logic                   csr_tready;
   logic [CSR_TDATA_W-1:0] csr_tdata  = '0;

   // shadow of the block
   logic [HASH_W-1:0] path_acc = FNV_BASIS;
   logic [HASH_W-1:0] slot_shadow [DEPTH];
   logic [CFG_W-1:0]  entries_shadow = '0;
   lookup_result_type lookup_results [$];

   // paths whose hashes were loaded into slots
   logic [BYTE_W-1:0] slot_path [DEPTH][MAX_PATH];
   int unsigned       slot_path_len [DEPTH];

   bit          no_gaps  = 1'b0;
   bit          hold_req = 1'b0;
   int unsigned errors   = 0;
   int unsigned quiet_cycles = 0;
   int unsigned n_items = 0, n_bytes = 0, n_lookups = 0, n_hits = 0;
   int unsigned n_writes = 0, n_unused = 0, n_cfg = 0;

   fnv1a_path_hash_index_lookup #(
      .TABLE_DEPTH (DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] b);
      return (acc ^ {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b}) * FNV_PRIME;
   endfunction

   task automatic predict_item(input req_item_type it);
      lookup_result_type res;
      int unsigned       limit;
      case (it.opcode)
         OPC_BYTE: begin
            path_acc = fnv_fold(path_acc, it.path_byte);
            n_bytes++;
         end
         OPC_LOOKUP: begin
            limit = (entries_shadow > DEPTH) ? DEPTH : entries_shadow;
            res = '0;
            res.path_hash = path_acc;
            for (int i = 0; i < limit; i++) begin
               if (!res.found && slot_shadow[i] == path_acc) begin
                  res.found       = 1'b1;
                  res.entry_index = i[IDX_W-1:0];
               end
            end
            lookup_results.push_back(res);
            path_acc = FNV_BASIS;
            n_lookups++;
            if (res.found) n_hits++;
         end
         OPC_WRITE: begin
            slot_shadow[it.write_slot] = it.write_hash;
            n_writes++;
         end
         default: begin
            n_unused++;
         end
      endcase
      if (it.opcode != OPC_NONE) n_items++;
   endtask

   // ---- result checking ----
   task automatic check_field(input string name, input logic [HASH_W-1:0] want,
                              input logic [HASH_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : check_results
      lookup_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (lookup_results.size() == 0) begin
            $display("%0t: result with none expected, expected none, actual %h", $time, got);
            errors++;
         end else begin
            want = lookup_results.pop_front();
            check_field("found", HASH_W'(want.found), HASH_W'(got.found));
            check_field("entry_index", HASH_W'(want.entry_index), HASH_W'(got.entry_index));
            check_field("path_hash", want.path_hash, got.path_hash);
            check_field("pad bit", '0, HASH_W'(got.pad));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_tvalid && csr_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---- rsp side: random stalls, one long hold-off on request ----
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ---- req side ----
   task automatic send_item(input req_item_type it);
      if (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.opcode;
      req_tdata  <= REQ_TDATA_W'({it.write_hash, it.write_slot, it.path_byte});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(it);
   endtask

   function automatic req_item_type make_item(input opcode_type op);
      req_item_type it;
      it.opcode     = op;
      it.path_byte  = BYTE_W'($urandom);
      it.write_slot = SLOT_W'($urandom);
      it.write_hash = $urandom;
      return it;
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      req_item_type it;
      it = make_item(OPC_BYTE);
      it.path_byte = b;
      send_item(it);
   endtask

   task automatic send_write(input int unsigned slot, input logic [HASH_W-1:0] h);
      req_item_type it;
      it = make_item(OPC_WRITE);
      it.write_slot = slot[SLOT_W-1:0];
      it.write_hash = h;
      send_item(it);
   endtask

   // load a slot with the hash of a fresh random path and remember the path
   task automatic store_new_path(input int unsigned slot);
      logic [HASH_W-1:0] h;
      h = FNV_BASIS;
      slot_path_len[slot] = $urandom_range(0, MAX_PATH);
      for (int k = 0; k < slot_path_len[slot]; k++) begin
         slot_path[slot][k] = BYTE_W'($urandom);
         h = fnv_fold(h, slot_path[slot][k]);
      end
      send_write(slot, h);
   endtask

   task automatic send_path(input int unsigned slot, input bit noisy);
      for (int k = 0; k < slot_path_len[slot]; k++) begin
         if (noisy && $urandom_range(99) < 8) begin
            send_item(make_item($urandom_range(1) ? OPC_NONE : OPC_WRITE));
         end
         send_byte(slot_path[slot][k]);
      end
      send_item(make_item(OPC_LOOKUP));
   endtask

   task automatic send_random_path(input int unsigned len);
      for (int k = 0; k < len; k++) send_item(make_item(OPC_BYTE));
      send_item(make_item(OPC_LOOKUP));
   endtask

   // sender pauses until every lookup has answered and the block has settled
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (lookup_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_entries(input logic [CFG_W-1:0] n);
      wait_drained();
      csr_tdata  <= CSR_TDATA_W'(n);
      csr_tvalid <= 1'b1;
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      csr_tvalid <= 1'b0;
      entries_shadow = n;
      n_cfg++;
   endtask

   // ---- tests ----
   task automatic test_empty_table();
      send_item(make_item(OPC_LOOKUP));
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(8'hFF);
      send_item(make_item(OPC_NONE));
      send_item(make_item(OPC_LOOKUP));
      send_byte(8'h41);
      send_write(3, $urandom);
      send_byte(8'h2F);
      send_item(make_item(OPC_LOOKUP));
      write_entries(0);
      send_random_path(3);
   endtask

   task automatic test_fill_table();
      for (int s = 0; s < DEPTH; s++) store_new_path(s);
      // duplicate hash: the lower slot must win
      slot_path[40] = slot_path[20];
      slot_path_len[40] = slot_path_len[20];
      send_write(40, slot_shadow[20]);
      send_write(61, 32'hFFFF_FFFF);
      send_write(62, 32'h0000_0000);
      write_entries(DEPTH);
      send_path(0, 1'b0);
      send_path(63, 1'b0);
      send_path(40, 1'b0);
      send_random_path(MAX_PATH);
   endtask

   task automatic test_entry_limits();
      logic [CFG_W-1:0] sizes [5] = '{7'd1, 7'd63, 7'd65, 7'd127, 7'd0};
      foreach (sizes[i]) begin
         write_entries(sizes[i]);
         send_path(0, 1'b0);
         send_path(63, 1'b0);
      end
      write_entries(DEPTH);
   endtask

   task automatic test_backpressure();
      hold_req = 1'b1;
      for (int i = 0; i < 40; i++) send_path($urandom_range(DEPTH - 1), 1'b0);
      wait_drained();
   endtask

   task automatic test_drain_pause();
      send_path($urandom_range(DEPTH - 1), 1'b0);
      wait_drained();
      send_path($urandom_range(DEPTH - 1), 1'b0);
   endtask

   task automatic test_random();
      int unsigned first, sent, next_cfg, r;
      first    = n_items;
      sent     = 0;
      next_cfg = 150;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= next_cfg) begin
            case ($urandom_range(7))
               0:       write_entries(7'd0);
               1:       write_entries(7'd1);
               2:       write_entries(7'd65);
               3:       write_entries(7'd127);
               4, 5:    write_entries(7'(DEPTH));
               default: write_entries(7'($urandom_range(0, 127)));
            endcase
            next_cfg += 150;
         end
         no_gaps = (sent >= 800 && sent < 1100);
         r = $urandom_range(99);
         if (r < 45) begin
            send_path($urandom_range(DEPTH - 1), 1'b1);
         end else if (r < 55) begin
            send_random_path($urandom_range(0, MAX_PATH));
         end else if (r < 72) begin
            store_new_path($urandom_range(DEPTH - 1));
         end else if (r < 80) begin
            send_write($urandom_range(DEPTH - 1), slot_shadow[$urandom_range(DEPTH - 1)]);
         end else if (r < 88) begin
            send_item(make_item(OPC_WRITE));
         end else if (r < 94) begin
            send_item(make_item(OPC_NONE));
         end else begin
            send_item(make_item(OPC_BYTE));
         end
         sent = n_items - first;
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      foreach (slot_shadow[i]) slot_shadow[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_fill_table();
      test_entry_limits();
      test_backpressure();
      test_drain_pause();
      test_random();
      wait_drained();
      repeat (FINAL_CYCLES) @(posedge clock);
      if (lookup_results.size() != 0) begin
         $display("%0t: lookups never answered, expected 0 left, actual %0d", $time,
                  lookup_results.size());
         errors++;
      end
      $display("Run covered %0d items: %0d path bytes, %0d lookups (%0d hits), %0d table writes",
               n_items, n_bytes, n_lookups, n_hits, n_writes);
      $display("plus %0d unused opcodes, %0d table size settings from 0 to 127, rsp hold-off",
               n_unused, n_cfg);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
